[rtl/core/bbs_pkg.sv]
package bbs_pkg;

  // default geometry of both maps
  localparam int WORD_BITS_DEF = 64;
  localparam int MAP_WORDS_DEF = 64;

  // port field widths
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 6;
  localparam int DATA_W     = 64;
  localparam int START_W    = 12;
  localparam int POS_W      = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // length register after reset
  localparam int MAP_BITS_RST = 4096;

  // fixed-point shift of the reciprocal used to split a start bit into word and offset
  localparam int RECIP_SH = 20;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY       = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_BITS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_SWAP = 4'd1;

  // controller to datapath
  typedef struct packed {
    logic wr_first;
    logic wr_second;
    logic capture;
    logic early_miss;
    logic div_step;
    logic base_init;
    logic scan_en;
    logic finish;
  } bbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_past_len;
    logic ev_valid;
    logic ev_hit;
    logic ev_last;
  } bbs_stat_t;

endpackage

[rtl/core/bitmap_bit_search_core.sv]
// Load beats (kinds 0 and 1) write their map word while busy stays low.
// A query whose start is at or past the map length strobes its result in the cycle after start.
// Otherwise the result strobes once the scan ends, after n map words are scanned (1 to MAP_WORDS):
// ST_DIV and ST_BASE split the start bit into word and offset, then one word per cycle leaves the map RAM.
// out_valid is high for exactly one cycle; the receiver cannot stall it.
// Synchronous active-low reset clears the sequencer and byte swap, sets map length to 4096; maps stay unset.
module bitmap_bit_search_core #(
  parameter int WORD_BITS = bbs_pkg::WORD_BITS_DEF,
  parameter int MAP_WORDS = bbs_pkg::MAP_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [bbs_pkg::KIND_W-1:0]      in_kind,
  input  logic [bbs_pkg::IDX_W-1:0]       in_word_index,
  input  logic [bbs_pkg::DATA_W-1:0]      in_word_data,
  input  logic [bbs_pkg::START_W-1:0]     in_start_bit,
  input  logic                            in_backward,
  input  logic                            in_seek_zero,
  input  logic                            in_use_second_map,
  output logic                            out_valid,
  output logic [bbs_pkg::POS_W-1:0]       out_position,
  output logic                            out_found,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int POS_W = bbs_pkg::POS_W;
  localparam int TOTAL = MAP_WORDS * WORD_BITS;

  logic [POS_W-1:0]   map_bits_r;
  logic               byte_swap_r;
  logic [POS_W-1:0]   len;
  bbs_pkg::bbs_cmd_t  cmd;
  bbs_pkg::bbs_stat_t stat;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_bits_r  <= POS_W'(bbs_pkg::MAP_BITS_RST);
      byte_swap_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bbs_pkg::CFG_MAP_BITS:  map_bits_r  <= cfg_data[POS_W-1:0];
        bbs_pkg::CFG_BYTE_SWAP: byte_swap_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp the length to the storage size
  assign len = (int'(map_bits_r) > TOTAL) ? POS_W'(TOTAL) : map_bits_r;

  bbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bbs_datapath #(
    .WORD_BITS (WORD_BITS),
    .MAP_WORDS (MAP_WORDS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .len               (len),
    .byte_swap         (byte_swap_r),
    .in_word_index     (in_word_index),
    .in_word_data      (in_word_data),
    .in_start_bit      (in_start_bit),
    .in_backward       (in_backward),
    .in_seek_zero      (in_seek_zero),
    .in_use_second_map (in_use_second_map),
    .out_position      (out_position),
    .out_found         (out_found)
  );

endmodule

[rtl/core/bbs_ctrl.sv]
module bbs_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bbs_pkg::KIND_W-1:0]  in_kind,
  input  bbs_pkg::bbs_stat_t          stat,
  output bbs_pkg::bbs_cmd_t           cmd,
  output logic                        busy,
  output logic                        out_valid
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_BASE = 2'd2;
  localparam logic [1:0] ST_SCAN = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  // decode the accepted beat and sequence a query
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_kind)
            bbs_pkg::KIND_LOAD_FIRST:  cmd.wr_first  = 1'b1;
            bbs_pkg::KIND_LOAD_SECOND: cmd.wr_second = 1'b1;
            bbs_pkg::KIND_QUERY: begin
              if (stat.start_past_len) begin
                cmd.early_miss = 1'b1;
                out_valid_nxt  = 1'b1;
              end else begin
                cmd.capture = 1'b1;
                state_nxt   = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_BASE;
      end
      ST_BASE: begin
        cmd.base_init = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.ev_valid && (stat.ev_hit || stat.ev_last)) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/bbs_datapath.sv]
module bbs_datapath #(
  parameter int WORD_BITS = bbs_pkg::WORD_BITS_DEF,
  parameter int MAP_WORDS = bbs_pkg::MAP_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bbs_pkg::bbs_cmd_t             cmd,
  output bbs_pkg::bbs_stat_t            stat,
  input  logic [bbs_pkg::POS_W-1:0]     len,
  input  logic                          byte_swap,
  input  logic [bbs_pkg::IDX_W-1:0]     in_word_index,
  input  logic [bbs_pkg::DATA_W-1:0]    in_word_data,
  input  logic [bbs_pkg::START_W-1:0]   in_start_bit,
  input  logic                          in_backward,
  input  logic                          in_seek_zero,
  input  logic                          in_use_second_map,
  output logic [bbs_pkg::POS_W-1:0]     out_position,
  output logic                          out_found
);

  localparam int POS_W   = bbs_pkg::POS_W;
  localparam int START_W = bbs_pkg::START_W;
  localparam int AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OFF_W   = $clog2(WORD_BITS);
  localparam int RECIP   = (1 << bbs_pkg::RECIP_SH) / WORD_BITS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = START_W + RECIP_W;
  localparam int QW_W    = START_W + OFF_W + 1;

  // reverse the byte order of the low whole bytes of a word
  function automatic logic [WORD_BITS-1:0] swap_bytes(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS / 8; i++) begin
      r[8*(WORD_BITS/8-1-i) +: 8] = v[8*i +: 8];
    end
    return r;
  endfunction

  // binary index of a one-hot word
  function automatic logic [OFF_W-1:0] encode(input logic [WORD_BITS-1:0] oh);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < OFF_W; k++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (((i >> k) & 1) == 1) idx[k] = idx[k] | oh[i];
      end
    end
    return idx;
  endfunction

  function automatic logic [WORD_BITS-1:0] reverse(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] r;
    for (int i = 0; i < WORD_BITS; i++) r[i] = v[WORD_BITS-1-i];
    return r;
  endfunction

  // map storage
  logic [WORD_BITS-1:0] first_mem  [MAP_WORDS];
  logic [WORD_BITS-1:0] second_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_first_r;
  logic [WORD_BITS-1:0] rd_second_r;

  logic [15:0] wr_idx;
  logic        wr_ok;

  // query fields
  logic [START_W-1:0] start_r;
  logic               back_r;
  logic               zero_r;
  logic               both_r;
  logic [POS_W-1:0]   len_r;

  // word split
  logic [PROD_W-1:0]  prod;
  logic [START_W-1:0] q0_r;
  logic [QW_W-1:0]    qw;
  logic [POS_W-1:0]   rem;
  logic               fix;
  logic [POS_W-1:0]   base0;
  logic [START_W-1:0] q1;
  logic [AW-1:0]      addr0;

  // issue and evaluate stages
  logic [AW-1:0]      iss_addr_r;
  logic [POS_W-1:0]   iss_base_r;
  logic               iss_done_r;
  logic               iss_last;
  logic               issue;
  logic               ev_valid_r;
  logic [POS_W-1:0]   ev_base_r;
  logic [POS_W-1:0]   hi_q;

  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] sw;
  logic [WORD_BITS-1:0] bits;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] cand_rev;
  logic [WORD_BITS-1:0] oh_lo;
  logic [WORD_BITS-1:0] oh_hi;
  logic [OFF_W-1:0]     lo_off;
  logic [OFF_W-1:0]     hi_off;
  logic [POS_W-1:0]     lo_d;
  logic [POS_W-1:0]     hi_d;
  logic [OFF_W-1:0]     idx;
  logic                 hit;
  logic [POS_W-1:0]     hit_pos;
  logic                 ev_last;

  logic [POS_W-1:0]     position_r;
  logic                 found_r;

  // last word of the scan: word zero going down, word holding len-1 going up
  function automatic logic is_last(input logic [POS_W-1:0] base, input logic back,
                                   input logic [POS_W-1:0] ln);
    logic [POS_W:0] top;
    top = {1'b0, base} + (POS_W+1)'(WORD_BITS);
    return back ? (base == '0) : (top >= {1'b0, ln});
  endfunction

  // load and read both maps
  assign wr_idx = 16'(in_word_index);
  assign wr_ok  = (wr_idx < 16'(MAP_WORDS));

  always_ff @(posedge clk) begin
    if (cmd.wr_first && wr_ok) first_mem[wr_idx[AW-1:0]] <= in_word_data[WORD_BITS-1:0];
    if (cmd.wr_second && wr_ok) second_mem[wr_idx[AW-1:0]] <= in_word_data[WORD_BITS-1:0];
    rd_first_r  <= first_mem[iss_addr_r];
    rd_second_r <= second_mem[iss_addr_r];
  end

  assign stat.start_past_len = ({1'b0, in_start_bit} >= len);

  // split the start bit: estimate the word by reciprocal, then correct once
  assign prod  = PROD_W'(start_r) * PROD_W'(RECIP);
  assign qw    = QW_W'(q0_r) * QW_W'(WORD_BITS);
  assign rem   = POS_W'(start_r) - POS_W'(qw);
  assign fix   = (rem >= POS_W'(WORD_BITS));
  assign base0 = fix ? (POS_W'(qw) + POS_W'(WORD_BITS)) : POS_W'(qw);
  assign q1    = fix ? (q0_r + 1'b1) : q0_r;
  assign addr0 = q1[AW-1:0];

  // issue one word read a cycle until the end word has gone out
  assign issue    = cmd.scan_en && !iss_done_r;
  assign iss_last = is_last(iss_base_r, back_r, len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_done_r <= 1'b0;
      ev_valid_r <= 1'b0;
    end else if (cmd.base_init) begin
      iss_done_r <= 1'b0;
      ev_valid_r <= 1'b0;
    end else begin
      ev_valid_r <= issue;
      if (issue && iss_last) iss_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      start_r <= in_start_bit;
      back_r  <= in_backward;
      zero_r  <= in_seek_zero;
      both_r  <= in_use_second_map;
      len_r   <= len;
    end
    if (cmd.div_step) q0_r <= START_W'(prod >> bbs_pkg::RECIP_SH);
    if (cmd.base_init) begin
      iss_addr_r <= addr0;
      iss_base_r <= base0;
    end else if (issue && !iss_last) begin
      if (back_r) begin
        iss_addr_r <= iss_addr_r - 1'b1;
        iss_base_r <= iss_base_r - POS_W'(WORD_BITS);
      end else begin
        iss_addr_r <= iss_addr_r + 1'b1;
        iss_base_r <= iss_base_r + POS_W'(WORD_BITS);
      end
    end
    if (issue) ev_base_r <= iss_base_r;
  end

  // evaluate the word just read: window mask, then nearest match
  assign word = rd_first_r & (both_r ? rd_second_r : {WORD_BITS{1'b1}});
  assign sw   = byte_swap ? swap_bytes(word) : word;
  assign bits = sw ^ {WORD_BITS{zero_r}};

  assign hi_q   = back_r ? POS_W'(start_r) : (len_r - 1'b1);
  assign lo_d   = POS_W'(start_r) - ev_base_r;
  assign lo_off = (!back_r && (POS_W'(start_r) > ev_base_r)) ? lo_d[OFF_W-1:0] : '0;
  assign hi_d   = hi_q - ev_base_r;
  assign hi_off = (hi_d >= POS_W'(WORD_BITS - 1)) ? OFF_W'(WORD_BITS - 1) : hi_d[OFF_W-1:0];

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (OFF_W'(b) >= lo_off) && (OFF_W'(b) <= hi_off);
    end
  end

  assign cand     = bits & mask;
  assign cand_rev = reverse(cand);
  assign oh_lo    = cand & (~cand + 1'b1);
  assign oh_hi    = cand_rev & (~cand_rev + 1'b1);
  assign idx      = back_r ? (OFF_W'(WORD_BITS - 1) - encode(oh_hi)) : encode(oh_lo);
  assign hit      = |cand;
  assign hit_pos  = ev_base_r + POS_W'(idx);
  assign ev_last  = is_last(ev_base_r, back_r, len_r);

  assign stat.ev_valid = ev_valid_r;
  assign stat.ev_hit   = hit;
  assign stat.ev_last  = ev_last;

  // hold the result for its strobe cycle
  always_ff @(posedge clk) begin
    if (cmd.early_miss) begin
      position_r <= len;
      found_r    <= 1'b0;
    end else if (cmd.finish) begin
      position_r <= hit ? hit_pos : len_r;
      found_r    <= hit;
    end
  end

  assign out_position = position_r;
  assign out_found    = found_r;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int WORD_BITS_DEF = bbs_pkg::WORD_BITS_DEF;
  localparam int MAP_WORDS_DEF = bbs_pkg::MAP_WORDS_DEF;
  localparam int KIND_W        = bbs_pkg::KIND_W;
  localparam int IDX_W         = bbs_pkg::IDX_W;
  localparam int DATA_W        = bbs_pkg::DATA_W;
  localparam int START_W       = bbs_pkg::START_W;
  localparam int POS_W         = bbs_pkg::POS_W;
  localparam int CFG_IDX_W     = bbs_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = bbs_pkg::CFG_DATA_W;

  localparam int TOTAL_BITS    = WORD_BITS_DEF * MAP_WORDS_DEF;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 80;
  localparam int REPORT_MAX    = 10;

  // kind 3 is left undecoded by the block
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 4'd15;
  localparam logic [DATA_W-1:0]    ALL_ONES    = '1;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
  } search_result_t;

  typedef enum int { FILL_SPARSE, FILL_DENSE, FILL_MIXED } fill_style_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind;
  logic [IDX_W-1:0]      in_word_index;
  logic [DATA_W-1:0]     in_word_data;
  logic [START_W-1:0]    in_start_bit;
  logic                  in_backward;
  logic                  in_seek_zero;
  logic                  in_use_second_map;
  logic                  out_valid;
  logic [POS_W-1:0]      out_position;
  logic                  out_found;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow copy of the block's maps and registers
  logic [DATA_W-1:0] first_words  [MAP_WORDS_DEF];
  logic [DATA_W-1:0] second_words [MAP_WORDS_DEF];
  logic [POS_W-1:0]  map_len_cfg;
  logic              swap_cfg;

  search_result_t expected_hits [$];
  int             mismatch_count;
  int             quiet_cycles;
  int             burst_left;

  bitmap_bit_search_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_word_index     (in_word_index),
    .in_word_data      (in_word_data),
    .in_start_bit      (in_start_bit),
    .in_backward       (in_backward),
    .in_seek_zero      (in_seek_zero),
    .in_use_second_map (in_use_second_map),
    .out_valid         (out_valid),
    .out_position      (out_position),
    .out_found         (out_found),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // length register clamped to the map size
  function automatic int effective_len();
    return (map_len_cfg > TOTAL_BITS) ? TOTAL_BITS : int'(map_len_cfg);
  endfunction

  // walk from the start bit toward the nearest matching position
  function automatic search_result_t find_nearest(logic [START_W-1:0] from_bit,
                                                  logic back, logic seek_zero,
                                                  logic both);
    search_result_t hit;
    int len;
    int pos;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] view;
    len = effective_len();
    hit.position = POS_W'(len);
    hit.found = 1'b0;
    if (from_bit >= len) return hit;
    pos = from_bit;
    while (pos >= 0 && pos < len) begin
      word = first_words[pos / WORD_BITS_DEF];
      if (both) word &= second_words[pos / WORD_BITS_DEF];
      view = word;
      if (swap_cfg) begin
        for (int k = 0; k < WORD_BITS_DEF / 8; k++)
          view[8*k +: 8] = word[8*(WORD_BITS_DEF/8 - 1 - k) +: 8];
      end
      if (view[pos % WORD_BITS_DEF] ^ seek_zero) begin
        hit.position = POS_W'(pos);
        hit.found = 1'b1;
        return hit;
      end
      pos += back ? -1 : 1;
    end
    return hit;
  endfunction

  // mostly inside the map, now and then anywhere in the field
  function automatic logic [START_W-1:0] pick_start();
    int len;
    len = effective_len();
    if (len > 0 && $urandom_range(0, 4) != 0) return START_W'($urandom_range(0, len - 1));
    return START_W'($urandom);
  endfunction

  // long runs of zeros or ones push searches across many words
  function automatic logic [DATA_W-1:0] gen_word(fill_style_t style);
    logic [DATA_W-1:0] one_bit;
    logic [DATA_W-1:0] rnd;
    int pick;
    one_bit = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
    rnd = {$urandom, $urandom};
    pick = $urandom_range(0, 15);
    case (style)
      FILL_SPARSE: return (pick == 0) ? one_bit : (pick == 1) ? rnd : '0;
      FILL_DENSE:  return (pick == 0) ? ~one_bit : (pick == 1) ? rnd : ALL_ONES;
      default: begin
        return (pick < 2) ? '0 : (pick < 4) ? ALL_ONES : (pick < 6) ? one_bit :
               (pick < 8) ? ~one_bit : rnd;
      end
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
  endtask

  // drive one beat and hold it until the block takes it
  task automatic send_item(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                           logic [DATA_W-1:0] data, logic [START_W-1:0] from_bit,
                           logic back, logic seek_zero, logic both);
    @(negedge clk);
    start             <= 1'b1;
    in_kind           <= kind;
    in_word_index     <= idx;
    in_word_data      <= data;
    in_start_bit      <= from_bit;
    in_backward       <= back;
    in_seek_zero      <= seek_zero;
    in_use_second_map <= both;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    case (kind)
      bbs_pkg::KIND_LOAD_FIRST:  first_words[idx] = data;
      bbs_pkg::KIND_LOAD_SECOND: second_words[idx] = data;
      bbs_pkg::KIND_QUERY:
        expected_hits.push_back(find_nearest(from_bit, back, seek_zero, both));
      default: ;
    endcase
  endtask

  task automatic send_query(logic [START_W-1:0] from_bit, logic back, logic seek_zero,
                            logic both);
    send_item(bbs_pkg::KIND_QUERY, IDX_W'($urandom), {$urandom, $urandom}, from_bit, back,
              seek_zero, both);
  endtask

  task automatic send_load(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                           logic [DATA_W-1:0] data);
    send_item(kind, idx, data, START_W'($urandom), $urandom_range(0, 1),
              $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  task automatic rand_query();
    send_query(pick_start(), $urandom_range(0, 1), $urandom_range(0, 1),
               $urandom_range(0, 1));
  endtask

  task automatic idle(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // bursts of random length, random gaps between them
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    idle($urandom_range(1, 12));
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
  endtask

  // hold off until every expected result is in, then let a load finish
  task automatic drain();
    idle(1);
    while (expected_hits.size() != 0) @(posedge clk);
    idle(4);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == bbs_pkg::CFG_MAP_BITS) map_len_cfg = data[POS_W-1:0];
    else if (idx == bbs_pkg::CFG_BYTE_SWAP) swap_cfg = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_maps(fill_style_t style, bit paced);
    for (int w = 0; w < MAP_WORDS_DEF; w++) begin
      send_load(bbs_pkg::KIND_LOAD_FIRST, IDX_W'(w), gen_word(style));
      if (paced) pace();
      send_load(bbs_pkg::KIND_LOAD_SECOND, IDX_W'(w), gen_word(style));
      if (paced) pace();
    end
  endtask

  // every word of both maps gets written before any search reads it
  task automatic test_load_maps();
    fill_maps(FILL_MIXED, 1'b0);
  endtask

  task automatic test_directed_queries();
    // first map: empty low word, full top word; second map: full low word, end bits on top
    send_load(bbs_pkg::KIND_LOAD_FIRST, '0, '0);
    send_load(bbs_pkg::KIND_LOAD_FIRST, IDX_W'(MAP_WORDS_DEF - 1), ALL_ONES);
    send_load(bbs_pkg::KIND_LOAD_SECOND, '0, ALL_ONES);
    send_load(bbs_pkg::KIND_LOAD_SECOND, IDX_W'(MAP_WORDS_DEF - 1), {1'b1, 62'b0, 1'b1});
    send_query('0, 1'b0, 1'b0, 1'b0);
    send_query('1, 1'b1, 1'b0, 1'b0);
    send_query('1, 1'b0, 1'b0, 1'b0);
    send_query('0, 1'b1, 1'b0, 1'b0);
    send_query('0, 1'b0, 1'b1, 1'b0);
    send_query('1, 1'b1, 1'b1, 1'b0);
    send_query('0, 1'b0, 1'b0, 1'b1);
    send_query('1, 1'b1, 1'b0, 1'b1);
    send_query(START_W'(TOTAL_BITS - WORD_BITS_DEF), 1'b0, 1'b1, 1'b1);
    send_query('1, 1'b0, 1'b1, 1'b1);
    // undecoded kind: no result expected
    send_item(KIND_UNUSED, '1, ALL_ONES, '1, 1'b1, 1'b1, 1'b1);
    // short map: last bit, first bit past the end, far past the end
    write_cfg(bbs_pkg::CFG_MAP_BITS, 16'd100);
    send_query(START_W'(99), 1'b1, 1'b0, 1'b0);
    send_query(START_W'(99), 1'b0, 1'b1, 1'b0);
    send_query(START_W'(100), 1'b1, 1'b0, 1'b0);
    send_query('1, 1'b0, 1'b0, 1'b1);
    write_cfg(bbs_pkg::CFG_BYTE_SWAP, 16'd1);
    send_query('0, 1'b0, 1'b0, 1'b1);
    send_query(START_W'(63), 1'b1, 1'b1, 1'b1);
    write_cfg(CFG_SPARE, '1);
    send_query(START_W'(50), 1'b0, 1'b0, 1'b0);
    write_cfg(bbs_pkg::CFG_BYTE_SWAP, 16'd0);
    write_cfg(bbs_pkg::CFG_MAP_BITS, CFG_DATA_W'(bbs_pkg::MAP_BITS_RST));
  endtask

  // lengths at and around the edges, including oversized and masked-off high bits
  task automatic test_config_sweep();
    logic [CFG_DATA_W-1:0] lengths [12] = '{16'd0, 16'd1, 16'd63, 16'd64, 16'd65, 16'd2048,
                                             16'd4095, 16'd4096, 16'd4097, 16'd8191,
                                             16'hFFFF, 16'hE040};
    int len;
    for (int i = 0; i < 12; i++) begin
      write_cfg(bbs_pkg::CFG_MAP_BITS, lengths[i]);
      write_cfg(bbs_pkg::CFG_BYTE_SWAP,
                (CFG_DATA_W'($urandom) & ~16'd1) | CFG_DATA_W'(i % 2));
      len = effective_len();
      if (len > 0) send_query(START_W'(len - 1), $urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 1));
      if (len < TOTAL_BITS) send_query(START_W'(len), 1'b0, 1'b1, 1'b0);
      repeat (4) rand_query();
    end
  endtask

  task automatic test_random_traffic();
    fill_style_t style;
    int pick;
    for (int phase = 0; phase < 6; phase++) begin
      style = fill_style_t'(phase % 3);
      pick = $urandom_range(0, 5);
      case (pick)
        0: write_cfg(bbs_pkg::CFG_MAP_BITS, CFG_DATA_W'(bbs_pkg::MAP_BITS_RST));
        1: write_cfg(bbs_pkg::CFG_MAP_BITS, CFG_DATA_W'($urandom_range(1, 128)));
        2: write_cfg(bbs_pkg::CFG_MAP_BITS,
                     CFG_DATA_W'($urandom_range(1, MAP_WORDS_DEF) * WORD_BITS_DEF));
        3: write_cfg(bbs_pkg::CFG_MAP_BITS,
                     CFG_DATA_W'($urandom_range(TOTAL_BITS + 1, 8191)));
        4: write_cfg(bbs_pkg::CFG_MAP_BITS, CFG_DATA_W'($urandom));
        default: write_cfg(bbs_pkg::CFG_MAP_BITS, CFG_DATA_W'($urandom_range(0, TOTAL_BITS)));
      endcase
      write_cfg(bbs_pkg::CFG_BYTE_SWAP, CFG_DATA_W'($urandom));
      fill_maps(style, 1'b1);
      // mostly searches, some reloads, a little undecoded noise
      for (int n = 0; n < 120; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) rand_query();
        else if (pick < 19) send_load(bbs_pkg::KIND_LOAD_FIRST + KIND_W'($urandom_range(0, 1)),
                                      IDX_W'($urandom), gen_word(style));
        else send_item(KIND_UNUSED, IDX_W'($urandom), {$urandom, $urandom},
                       START_W'($urandom), $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 1));
        pace();
      end
    end
  endtask

  // compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    search_result_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (expected_hits.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: position %0d found %0b",
                                out_position, out_found));
      end else begin
        want = expected_hits.pop_front();
        if (out_position !== want.position)
          note_mismatch($sformatf("position: expected %0d, got %0d", want.position,
                                  out_position));
        if (out_found !== want.found)
          note_mismatch($sformatf("found: expected %0b, got %0b", want.found, out_found));
      end
    end
  end

  // end the run if no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_kind           = '0;
    in_word_index     = '0;
    in_word_data      = '0;
    in_start_bit      = '0;
    in_backward       = 1'b0;
    in_seek_zero      = 1'b0;
    in_use_second_map = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    map_len_cfg       = POS_W'(bbs_pkg::MAP_BITS_RST);
    swap_cfg          = 1'b0;
    mismatch_count    = 0;
    quiet_cycles      = 0;
    burst_left        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_load_maps();
    test_directed_queries();
    test_config_sweep();
    test_random_traffic();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_hits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bbs_pkg.sv
rtl/core/bbs_ctrl.sv
rtl/core/bbs_datapath.sv
rtl/core/bitmap_bit_search_core.sv
tb/tb_top.sv
